FILE: sv/srt_pkg.sv
`default_nettype none
package srt_pkg;
    typedef enum logic [2:0] {
        K_CHECK  = 3'd0,
        K_PLACE  = 3'd1,
        K_AUTO   = 3'd2,
        K_REMOVE = 3'd3,
        K_QUERY  = 3'd4
    } kind_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_IN_USE  = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic CFG_ADDR_LIMIT = 1'b0;
    localparam logic CFG_AUTO_BASE  = 1'b1;

    localparam logic [47:0] LIMIT_RESET = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] AUTO_BASE_RESET = 48'h0000_0050_0000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] address;
        logic [47:0] length;
        logic [2:0]  perms;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        granted;
        logic [2:0]  perms_out;
        logic [47:0] region_start;
        logic [47:0] region_size;
    } rsp_t;

    typedef struct packed {
        logic [47:0] start;
        logic [47:0] size;
        logic [2:0]  perms;
    } entry_t;
endpackage
`default_nettype wire

FILE: sv/sorted_region_table.sv
// check, query and remove scan the entries in order; removal shifts later ones down,
// placement shifts them up, and automatic placement first reads the last entry
// each entry is read (S_CMP), then compared (S_EVAL); a shifted one is read, then written
// one request at a time; the next is accepted in the cycle after the response leaves
// reset: table empty, addr_limit all ones, auto_base 0x500000
`default_nettype none
module sorted_region_table #(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_BITS = 12
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire srt_pkg::req_t   in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output srt_pkg::rsp_t        out_data,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [47:0]     cfg_data
);
    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam logic [48:0] PMASK = 49'((64'd1 << PAGE_BITS) - 64'd1);

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_RD, S_CMP, S_EVAL, S_SHR, S_SHW, S_PUT, S_RMR, S_RMW, S_DONE
    } state_t;

    state_t state_reg;
    logic [47:0] limit_reg, base_reg;
    logic [CW-1:0] count_reg, idx_reg, pos_reg;
    srt_pkg::req_t req_reg;
    srt_pkg::rsp_t rsp_reg;
    logic [47:0] start_reg, rsize_reg;

    logic mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    srt_pkg::entry_t mem_wdata, rd;

    srt_mem #(.DEPTH(MAX_REGIONS), .AW(AW)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(rd)
    );

    function automatic logic [48:0] pround(input logic [48:0] v);
        logic [49:0] t;
        t = {1'b0, v} + {1'b0, PMASK};
        return t[48:0] & ~PMASK;
    endfunction

    logic [48:0] req_end, rd_end, rsize_full, auto_start, pl_end, pl_lim;
    logic is_place;
    always_comb
    begin
        req_end = {1'b0, req_reg.address} + {1'b0, req_reg.length};
        rd_end = {1'b0, rd.start} + {1'b0, rd.size};
        rsize_full = pround({1'b0, req_reg.length});
        auto_start = pround(rd_end);
        pl_end = {1'b0, start_reg} + {1'b0, rsize_reg};
        pl_lim = {1'b0, start_reg} + {1'b0, req_reg.length};
        is_place = (req_reg.kind == srt_pkg::K_PLACE) || (req_reg.kind == srt_pkg::K_AUTO);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign out_data = rsp_reg;

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_SHR:
            begin
                mem_raddr = AW'(idx_reg - CW'(1));
            end
            S_SHW:
            begin
                mem_we = 1'b1;
                mem_waddr = idx_reg[AW-1:0];
                mem_wdata = rd;
            end
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_waddr = pos_reg[AW-1:0];
                mem_wdata = '{start: start_reg, size: rsize_reg, perms: req_reg.perms};
            end
            S_RMW:
            begin
                mem_we = 1'b1;
                mem_waddr = AW'(idx_reg - CW'(1));
                mem_wdata = rd;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= srt_pkg::LIMIT_RESET;
            base_reg <= srt_pkg::AUTO_BASE_RESET;
            count_reg <= '0;
            idx_reg <= '0;
            pos_reg <= '0;
            req_reg <= '0;
            rsp_reg <= '0;
            start_reg <= '0;
            rsize_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == srt_pkg::CFG_ADDR_LIMIT)
                    limit_reg <= cfg_data;
                else
                    base_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg <= in_data;
                        rsp_reg <= '{status: srt_pkg::ST_INVALID, default: '0};
                        start_reg <= in_data.address;
                        idx_reg <= (in_data.kind == srt_pkg::K_AUTO && count_reg != '0)
                            ? CW'(count_reg - CW'(1)) : '0;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    // wait here for the read, then settle the start
                    rsize_reg <= rsize_full[47:0];
                    pos_reg <= count_reg;
                    if (req_reg.kind == srt_pkg::K_AUTO)
                    begin
                        if (count_reg == '0)
                            start_reg <= base_reg;
                        state_reg <= S_RD;
                    end
                    else if (is_place || req_reg.kind == srt_pkg::K_CHECK
                             || req_reg.kind == srt_pkg::K_QUERY
                             || req_reg.kind == srt_pkg::K_REMOVE)
                        state_reg <= S_CMP;
                    else
                        state_reg <= S_DONE;
                end
                S_RD:
                begin
                    // auto start from last entry (read data valid here)
                    if (count_reg != '0)
                    begin
                        if (auto_start[48])
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            start_reg <= auto_start[47:0];
                            state_reg <= S_CMP;
                        end
                    end
                    else
                        state_reg <= S_CMP;
                    idx_reg <= '0;
                end
                S_CMP:
                begin
                    if (is_place && (pl_lim > {1'b0, limit_reg} || pl_end[48]
                                     || rsize_full[48]))
                        state_reg <= S_DONE;
                    else if (idx_reg == count_reg)
                    begin
                        if (is_place)
                        begin
                            if (count_reg >= CW'(MAX_REGIONS))
                            begin
                                rsp_reg.status <= srt_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg <= count_reg;
                                state_reg <= S_SHR;
                            end
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (req_reg.kind == srt_pkg::K_CHECK || req_reg.kind == srt_pkg::K_QUERY)
                    begin
                        if (!req_end[48] && rd.start <= req_reg.address && req_end <= rd_end)
                        begin
                            rsp_reg.status <= srt_pkg::ST_OK;
                            rsp_reg.perms_out <= rd.perms;
                            rsp_reg.granted <= (req_reg.kind == srt_pkg::K_CHECK)
                                && ((rd.perms & req_reg.perms) == req_reg.perms);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            idx_reg <= CW'(idx_reg + CW'(1));
                            state_reg <= S_CMP;
                        end
                    end
                    else if (req_reg.kind == srt_pkg::K_REMOVE)
                    begin
                        idx_reg <= CW'(idx_reg + CW'(1));
                        if (rd.start == req_reg.address && rd.size == req_reg.length)
                            state_reg <= S_RMR;
                        else
                            state_reg <= S_CMP;
                    end
                    else
                    begin
                        if ({1'b0, rd.start} < pl_end && {1'b0, start_reg} < rd_end)
                        begin
                            rsp_reg.status <= srt_pkg::ST_IN_USE;
                            state_reg <= S_DONE;
                        end
                        else if ({1'b0, rd.start} >= pl_end)
                        begin
                            pos_reg <= idx_reg;
                            if (count_reg >= CW'(MAX_REGIONS))
                            begin
                                rsp_reg.status <= srt_pkg::ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                idx_reg <= count_reg;
                                state_reg <= S_SHR;
                            end
                        end
                        else
                        begin
                            idx_reg <= CW'(idx_reg + CW'(1));
                            state_reg <= S_CMP;
                        end
                    end
                end
                S_SHR:
                begin
                    // read entry idx-1 here, write it to idx next cycle
                    if (idx_reg == pos_reg)
                        state_reg <= S_PUT;
                    else
                        state_reg <= S_SHW;
                end
                S_SHW:
                begin
                    idx_reg <= CW'(idx_reg - CW'(1));
                    state_reg <= S_SHR;
                end
                S_PUT:
                begin
                    count_reg <= CW'(count_reg + CW'(1));
                    rsp_reg.status <= srt_pkg::ST_OK;
                    rsp_reg.region_start <= start_reg;
                    rsp_reg.region_size <= rsize_reg;
                    state_reg <= S_DONE;
                end
                S_RMR:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        count_reg <= CW'(count_reg - CW'(1));
                        rsp_reg.status <= srt_pkg::ST_OK;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_RMW;
                end
                S_RMW:
                begin
                    idx_reg <= CW'(idx_reg + CW'(1));
                    state_reg <= S_RMR;
                end
                S_DONE:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: sv/srt_mem.sv
`default_nettype none
module srt_mem #(
    parameter int DEPTH = 16,
    parameter int AW = 4
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire srt_pkg::entry_t     wdata,
    input  wire logic [AW-1:0]       raddr,
    output srt_pkg::entry_t          rdata
);
    srt_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: test/sorted_region_table_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sorted_region_table_checker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire srt_pkg::req_t   in_data,
    input  wire logic            out_valid,
    input  wire logic            out_ready,
    input  wire srt_pkg::rsp_t   out_data,
    input  wire logic            cfg_we,
    input  wire logic            cfg_index,
    input  wire logic [47:0]     cfg_data,
    output int                   errors,
    output int                   pending
);
    localparam int NREG = 16;
    localparam int QDEPTH = 8;
    localparam logic [63:0] PMASK = 64'hFFF;
    localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;

    logic [63:0]   limit_q, base_q;
    logic [63:0]   tbl_start [NREG];
    logic [63:0]   tbl_size [NREG];
    logic [2:0]    tbl_perms [NREG];
    int            tbl_count;
    srt_pkg::rsp_t expected_rsps [QDEPTH];
    int            wr_ptr, rd_ptr;

    function automatic logic [63:0] page_up(logic [63:0] v);
        return (v + PMASK) & ~PMASK;
    endfunction

    function automatic int holder(logic [63:0] a, logic [63:0] l);
        logic [63:0] e;
        e = a + l;
        if (e > MASK48)
            return -1;
        for (int i = 0; i < tbl_count; i++)
            if (tbl_start[i] <= a && e <= tbl_start[i] + tbl_size[i])
                return i;
        return -1;
    endfunction

    function automatic srt_pkg::rsp_t apply_request(srt_pkg::req_t r);
        srt_pkg::rsp_t o;
        int            h, pos, hit;
        logic [63:0]   st, rsize, e, s, en;
        o = '0;
        o.status = srt_pkg::ST_INVALID;
        case (r.kind)
            srt_pkg::K_CHECK, srt_pkg::K_QUERY:
            begin
                h = holder(64'(r.address), 64'(r.length));
                if (h >= 0)
                begin
                    o.status = srt_pkg::ST_OK;
                    o.perms_out = tbl_perms[h];
                    if (r.kind == srt_pkg::K_CHECK && (tbl_perms[h] & r.perms) == r.perms)
                        o.granted = 1'b1;
                end
            end
            srt_pkg::K_PLACE, srt_pkg::K_AUTO:
            begin
                rsize = page_up(64'(r.length));
                st = 64'(r.address);
                if (r.kind == srt_pkg::K_AUTO)
                    st = (tbl_count == 0) ? base_q :
                        page_up(tbl_start[tbl_count-1] + tbl_size[tbl_count-1]);
                en = st + rsize;
                if (st > MASK48 || st + 64'(r.length) > limit_q || en > MASK48)
                    return o;
                pos = tbl_count;
                for (int i = 0; i < tbl_count; i++)
                begin
                    s = tbl_start[i];
                    e = s + tbl_size[i];
                    if (s < en && st < e)
                    begin
                        o.status = srt_pkg::ST_IN_USE;
                        return o;
                    end
                    if (s >= en)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (tbl_count >= NREG)
                begin
                    o.status = srt_pkg::ST_FULL;
                    return o;
                end
                for (int i = tbl_count; i > pos; i--)
                begin
                    tbl_start[i] = tbl_start[i-1];
                    tbl_size[i] = tbl_size[i-1];
                    tbl_perms[i] = tbl_perms[i-1];
                end
                tbl_start[pos] = st;
                tbl_size[pos] = rsize;
                tbl_perms[pos] = r.perms;
                tbl_count++;
                o.status = srt_pkg::ST_OK;
                o.region_start = st[47:0];
                o.region_size = rsize[47:0];
            end
            srt_pkg::K_REMOVE:
            begin
                hit = -1;
                for (int i = 0; i < tbl_count; i++)
                    if (hit < 0 && tbl_start[i] == 64'(r.address)
                        && tbl_size[i] == 64'(r.length))
                        hit = i;
                if (hit >= 0)
                begin
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_start[j] = tbl_start[j+1];
                        tbl_size[j] = tbl_size[j+1];
                        tbl_perms[j] = tbl_perms[j+1];
                    end
                    tbl_count--;
                    o.status = srt_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    assign pending = wr_ptr - rd_ptr;

    always @(posedge clk or negedge rst_n)
    begin
        srt_pkg::rsp_t w;
        if (!rst_n)
        begin
            limit_q <= {16'd0, srt_pkg::LIMIT_RESET};
            base_q <= {16'd0, srt_pkg::AUTO_BASE_RESET};
            tbl_count = 0;
            errors = 0;
            wr_ptr = 0;
            rd_ptr = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == srt_pkg::CFG_ADDR_LIMIT)
                    limit_q <= {16'd0, cfg_data};
                else
                    base_q <= {16'd0, cfg_data};
            end
            if (out_valid && out_ready)
            begin
                if (wr_ptr == rd_ptr)
                    report_mismatch("unexpected response", 64'(out_data.status), 64'd0);
                else
                begin
                    w = expected_rsps[rd_ptr % QDEPTH];
                    rd_ptr++;
                    if (out_data.status !== w.status)
                        report_mismatch("status", 64'(out_data.status), 64'(w.status));
                    if (out_data.granted !== w.granted)
                        report_mismatch("granted", 64'(out_data.granted), 64'(w.granted));
                    if (out_data.perms_out !== w.perms_out)
                        report_mismatch("perms_out", 64'(out_data.perms_out),
                            64'(w.perms_out));
                    if (out_data.region_start !== w.region_start)
                        report_mismatch("region_start", 64'(out_data.region_start),
                            64'(w.region_start));
                    if (out_data.region_size !== w.region_size)
                        report_mismatch("region_size", 64'(out_data.region_size),
                            64'(w.region_size));
                end
            end
            if (in_valid && in_ready)
            begin
                expected_rsps[wr_ptr % QDEPTH] = apply_request(in_data);
                wr_ptr++;
            end
        end
    end
endmodule
`default_nettype wire

FILE: test/sorted_region_table_test.sv
`timescale 1ns / 1ps
`default_nettype none
module sorted_region_table_test;
    localparam int WATCHDOG = 20000;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    srt_pkg::req_t in_data;
    logic          out_valid;
    logic          out_ready;
    srt_pkg::rsp_t out_data;
    logic          cfg_we;
    logic          cfg_index;
    logic [47:0]   cfg_data;
    int            errors;
    int            pending;
    int            idle_cycles;
    bit            stall_on;

    sorted_region_table dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    sorted_region_table_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // response side stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = stall_on ? $urandom_range(0, 4) : 0;
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // valid stays up after acceptance until the next request or an idle gap drops it
    task automatic send_request(logic [2:0] k, logic [47:0] a, logic [47:0] l,
        logic [2:0] p);
        int gap;
        gap = stall_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{kind: k, address: a, length: l, perms: p};
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic idx, logic [47:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // mostly small aligned addresses near the working window
    function automatic logic [47:0] pick_addr(logic [47:0] base);
        case ($urandom_range(0, 9))
            0: return rand48();
            1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 8192));
            2: return base + 48'($urandom_range(0, 40000));
            default: return base + (48'($urandom_range(0, 40)) << 12);
        endcase
    endfunction

    function automatic logic [47:0] pick_len();
        case ($urandom_range(0, 9))
            0: return rand48();
            1: return 48'd0;
            2: return 48'($urandom_range(1, 5000));
            default: return 48'($urandom_range(1, 4)) << 12;
        endcase
    endfunction

    task automatic random_phase(int n, logic [47:0] base);
        logic [2:0] k;
        for (int i = 0; i < n; i++)
        begin
            stall_on = (i % 200) >= 40;
            case ($urandom_range(0, 19))
                0: k = 3'($urandom_range(5, 7));
                1, 2, 3, 4: k = srt_pkg::K_CHECK;
                5, 6, 7: k = srt_pkg::K_QUERY;
                8, 9, 10, 11: k = srt_pkg::K_PLACE;
                12, 13, 14: k = srt_pkg::K_AUTO;
                default: k = srt_pkg::K_REMOVE;
            endcase
            send_request(k, pick_addr(base), pick_len(), 3'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = srt_pkg::CFG_ADDR_LIMIT;
        cfg_data = '0;
        stall_on = 1'b1;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_request(srt_pkg::K_CHECK, 48'h0, 48'h0, 3'd7);
        send_request(srt_pkg::K_AUTO, 48'h0, 48'h1, 3'd7);
        send_request(srt_pkg::K_AUTO, 48'h0, 48'h0, 3'd1);
        send_request(srt_pkg::K_AUTO, 48'h0, 48'h2000, 3'd3);
        send_request(srt_pkg::K_PLACE, 48'h501000, 48'h10, 3'd2);
        send_request(srt_pkg::K_CHECK, 48'h500000, 48'h1000, 3'd7);
        send_request(srt_pkg::K_CHECK, 48'h500000, 48'h1000, 3'd5);
        send_request(srt_pkg::K_CHECK, 48'h501000, 48'h0, 3'd0);
        send_request(srt_pkg::K_QUERY, 48'h501800, 48'h100, 3'd0);
        send_request(srt_pkg::K_QUERY, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 3'd0);
        send_request(srt_pkg::K_PLACE, 48'hFFFF_FFFF_F000, 48'h1, 3'd7);
        send_request(srt_pkg::K_PLACE, 48'hFFFF_FFFF_F000, 48'h1000, 3'd7);
        send_request(srt_pkg::K_AUTO, 48'h0, 48'h1000, 3'd4);
        send_request(srt_pkg::K_PLACE, 48'h0, 48'hFFFF_FFFF_FFFF, 3'd7);
        send_request(srt_pkg::K_REMOVE, 48'h501000, 48'h1000, 3'd0);
        send_request(srt_pkg::K_REMOVE, 48'h501000, 48'h1000, 3'd0);
        send_request(3'd5, 48'hFFFF_FFFF_FFFF, 48'h1, 3'd7);
        send_request(3'd7, 48'h0, 48'h0, 3'd0);
        for (int i = 0; i < 17; i++)
            send_request(srt_pkg::K_PLACE, 48'h10_0000 + (48'(i) << 12), 48'h800, i[2:0]);

        write_reg(srt_pkg::CFG_ADDR_LIMIT, 48'h0);
        write_reg(srt_pkg::CFG_AUTO_BASE, 48'h0);
        send_request(srt_pkg::K_PLACE, 48'h0, 48'h0, 3'd1);
        send_request(srt_pkg::K_PLACE, 48'h0, 48'h1, 3'd1);

        write_reg(srt_pkg::CFG_ADDR_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(srt_pkg::CFG_AUTO_BASE, 48'h20_0000);
        random_phase(600, 48'h20_0000);
        write_reg(srt_pkg::CFG_ADDR_LIMIT, 48'h24_0000);
        write_reg(srt_pkg::CFG_AUTO_BASE, 48'hFFFF_FFFF_E000);
        random_phase(400, 48'h20_0000);
        write_reg(srt_pkg::CFG_ADDR_LIMIT, rand48());
        write_reg(srt_pkg::CFG_AUTO_BASE, 48'hFFFF_FFFF_FFFF);
        random_phase(300, 48'hFFFF_FFF0_0000);
        write_reg(srt_pkg::CFG_ADDR_LIMIT, 48'hFFFF_FFFF_FFFF);
        write_reg(srt_pkg::CFG_AUTO_BASE, 48'h3000);
        random_phase(400, 48'h0);

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
sv/srt_pkg.sv
sv/srt_mem.sv
sv/sorted_region_table.sv
test/sorted_region_table_checker.sv
test/sorted_region_table_test.sv
